FILE: sv/cle_pkg.sv
package cle_pkg;

   // line store geometry
   localparam int LINE_DEPTH = 64;
   localparam int CNT_W      = $clog2(LINE_DEPTH);
   localparam int LEN_W      = 6;
   localparam int IDX_W      = 6;
   // wider than both the read index and the line count at this depth
   localparam int CMP_W      = 9;

   // special bytes
   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_ESC  = 8'h1B;
   localparam logic [7:0] CH_BS   = 8'h08;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_TILD = 8'h7E;

   // input actions
   localparam logic ACT_RX   = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // result kinds
   typedef enum logic [1:0] {
      KIND_ECHO    = 2'd0,
      KIND_NEWLINE = 2'd1,
      KIND_READ    = 2'd2
   } kind_type;

   typedef struct packed {
      logic             action;
      logic [7:0]       rx_byte;
      logic [IDX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data_byte;
      logic [LEN_W-1:0] line_length;
      logic             last;
   } rsp_type;

endpackage

FILE: sv/cle_ram.sv
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/console_line_editor.sv
// Console line editor: takes received bytes (or read requests) on the req_
// channel and returns echo bytes, a newline with line-complete, or stored
// characters on the rsp_ channel. One item is accepted per clock while
// req_stall is low; an item is decoded and the line state updated in the
// cycle it is accepted, and its results leave through a holding stage and
// an output register, so a result waiting in the output register does not
// block the next item while the holding stage is free or can move on. A
// backspace that deletes a character produces three results (backspace,
// space, backspace) and holds off input until the third of them moves to
// the output register; every other item produces at most one result, and
// zero bytes, ESC sequences and dropped bytes produce none.
// Line characters sit in a single-port-write RAM with registered read; a
// read returns 0 at or beyond the current line length. No clearing pass is
// needed after reset.
module console_line_editor (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cle_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cle_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ESC_IDLE = 2'd0,
      ESC_SEEN = 2'd1,
      ESC_SKIP = 2'd2
   } esc_type;

   typedef struct packed {
      cle_pkg::kind_type              kind;
      logic [7:0]                     data_byte;
      logic [cle_pkg::CNT_W-1:0]      length;
      logic                           multi;
      logic                           hit;
   } hold_type;

   localparam logic [1:0] STEP_SPACE = 2'd1;
   localparam logic [1:0] STEP_LAST  = 2'd2;

   // line state
   logic [cle_pkg::CNT_W-1:0] count_ff, count_in, count_eff;
   logic                      done_ff, done_in;
   esc_type                   esc_ff, esc_in;

   // holding stage and output register
   logic             hold_valid_ff;
   hold_type         hold_ff, hold_in;
   logic [1:0]       step_ff;
   logic             rsp_valid_ff;
   cle_pkg::rsp_type rsp_ff, rsp_in;

   logic req_accept, emit, hold_last, out_load;
   logic wr_en, rd_en;
   logic [cle_pkg::CNT_W-1:0] rd_addr;
   logic [7:0] rd_data;
   logic [7:0] rx;

   assign rx        = req_data.rx_byte;
   assign hold_last = !hold_ff.multi || (step_ff == STEP_LAST);
   assign out_load  = hold_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = hold_valid_ff && !(out_load && hold_last);
   assign req_accept = req_valid && !req_stall;
   assign rd_addr   = cle_pkg::CNT_W'(req_data.read_index);
   assign rd_en     = req_accept && (req_data.action == cle_pkg::ACT_READ);

   // decode the item and update the line state
   always_comb begin
      count_in  = count_ff;
      done_in   = done_ff;
      esc_in    = esc_ff;
      wr_en     = 1'b0;
      emit      = 1'b0;
      count_eff = done_ff ? '0 : count_ff;
      hold_in   = '{kind: cle_pkg::KIND_ECHO, data_byte: rx, length: count_ff,
                    multi: 1'b0, hit: 1'b0};
      if (req_accept) begin
         if (req_data.action == cle_pkg::ACT_READ) begin
            emit         = 1'b1;
            hold_in.kind = cle_pkg::KIND_READ;
            hold_in.hit  = cle_pkg::CMP_W'(req_data.read_index) <
                           cle_pkg::CMP_W'(count_ff);
         end else if (rx != cle_pkg::CH_NUL) begin
            count_in = count_eff;
            done_in  = 1'b0;
            priority if (rx == cle_pkg::CH_LF || rx == cle_pkg::CH_CR) begin
               done_in           = 1'b1;
               esc_in            = ESC_IDLE;
               emit              = 1'b1;
               hold_in.kind      = cle_pkg::KIND_NEWLINE;
               hold_in.data_byte = cle_pkg::CH_LF;
               hold_in.length    = count_eff;
            end else if (rx == cle_pkg::CH_ESC) begin
               esc_in = (esc_ff == ESC_IDLE) ? ESC_SEEN : ESC_IDLE;
            end else if (rx == cle_pkg::CH_BS) begin
               if (esc_ff != ESC_IDLE) begin
                  esc_in = ESC_IDLE;
               end else if (count_eff != '0) begin
                  count_in       = count_eff - 1'b1;
                  emit           = 1'b1;
                  hold_in.multi  = 1'b1;
                  hold_in.length = count_eff - 1'b1;
               end
            end else if (esc_ff == ESC_SEEN) begin
               esc_in = ESC_SKIP;
            end else if (esc_ff != ESC_IDLE) begin
               esc_in = ESC_IDLE;
            end else if (rx >= cle_pkg::CH_SP && rx <= cle_pkg::CH_TILD &&
                         count_eff < cle_pkg::CNT_W'(cle_pkg::LINE_DEPTH - 1)) begin
               wr_en          = 1'b1;
               count_in       = count_eff + 1'b1;
               emit           = 1'b1;
               hold_in.length = count_eff + 1'b1;
            end else begin
               // control or high byte, or printable on a full line: dropped
            end
         end
      end
   end

   // form the next result from the holding stage
   always_comb begin
      rsp_in.kind        = hold_ff.kind;
      rsp_in.line_length = cle_pkg::LEN_W'(hold_ff.length);
      rsp_in.last        = hold_last;
      if (hold_ff.kind == cle_pkg::KIND_READ) begin
         rsp_in.data_byte = hold_ff.hit ? rd_data : 8'h00;
      end else if (hold_ff.multi) begin
         rsp_in.data_byte = (step_ff == STEP_SPACE) ? cle_pkg::CH_SP : cle_pkg::CH_BS;
      end else begin
         rsp_in.data_byte = hold_ff.data_byte;
      end
   end

   // line store
   cle_ram #(
      .WIDTH (8),
      .DEPTH (cle_pkg::LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_eff),
      .wr_data (rx),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // state, holding stage and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         done_ff       <= 1'b0;
         esc_ff        <= ESC_IDLE;
         hold_valid_ff <= 1'b0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
         esc_ff   <= esc_in;
         if (req_accept && emit) begin
            hold_valid_ff <= 1'b1;
            step_ff       <= '0;
            hold_ff       <= hold_in;
         end else if (out_load && hold_last) begin
            hold_valid_ff <= 1'b0;
         end else if (out_load) begin
            step_ff <= step_ff + 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= rsp_in;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
